@@ rtl/ghamcc_pkg.sv @@
// Shared types and constants for the guest/host address map with call cache.
// Used by the top level; depends on nothing.
package ghamcc_pkg;

  localparam int DefMapEntries = 64;
  localparam int DefCacheSlots = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CALL   = 2'd2;
  localparam logic [1:0] CMD_RETURN = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] virt_addr;
    logic [63:0] host_addr_in;
    logic [63:0] ret_virt_addr;
    logic [63:0] ret_host_addr;
  } in_t;

  typedef struct packed {
    logic [63:0] host_addr;
    logic        insert_dropped;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
  } map_word_t;

  typedef struct packed {
    logic [63:0] virt;
    logic [63:0] host;
  } cache_word_t;

endpackage

@@ rtl/ghamcc_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module ghamcc_ram #(
  parameter  int WIDTH = 128,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/guest_host_address_map_with_call_cache_unit.sv @@
// Guest-to-host code address map with a call/return cache: top level.
// Uses ghamcc_pkg and two ghamcc_ram instances (map store, call cache store).
//
// One transaction is worked on at a time. Insert, lookup and call scan the stored map keys
// in the map memory, one key per cycle, stopping at the first match and reading at most
// map_count keys (at most MAP_ENTRIES). A return first scans the call cache memory, one
// slot per cycle, falls back to a map scan when none of the CACHE_SLOTS slots matches,
// and ends early on a hit. The single read port of the map memory sets the pace.
// The result sits in an output register, so the next transaction is taken while a result
// still waits.
// Neither memory needs a clearing pass after reset: the map is only read below its fill
// count and cache slots carry valid bits in flip-flops.
module guest_host_address_map_with_call_cache_unit #(
  parameter int MAP_ENTRIES = ghamcc_pkg::DefMapEntries,
  parameter int CACHE_SLOTS = ghamcc_pkg::DefCacheSlots
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ghamcc_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ghamcc_pkg::out_t out_data_o
);
  import ghamcc_pkg::*;

  localparam int MIDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int MCNT_W = $clog2(MAP_ENTRIES + 1);
  localparam int SIDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int SCNT_W = $clog2(CACHE_SLOTS + 1);
  localparam int CNT_W  = (MCNT_W > SCNT_W) ? MCNT_W : SCNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CSCAN = 2'd1;
  localparam logic [1:0] S_MSCAN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic                   chk_q, chk_d;
  logic [SIDX_W-1:0]      chk_slot_q, chk_slot_d;
  logic [MCNT_W-1:0]      map_count_q, map_count_d;
  logic [CACHE_SLOTS-1:0] valid_q, valid_d;
  logic                   out_valid_q, out_valid_d;
  in_t                    txn_q, txn_d;
  out_t                   res_q, res_d;
  out_t                   out_data_q, out_data_d;

  logic                   m_we, m_re;
  logic [MIDX_W-1:0]      m_waddr, m_raddr;
  map_word_t              m_wdata, m_rdata;
  logic                   c_we, c_re;
  logic [SIDX_W-1:0]      c_waddr, c_raddr;
  cache_word_t            c_wdata, c_rdata;

  logic                   in_acc;
  logic                   map_issue, m_hit, m_miss;
  logic                   c_issue, c_hit, c_miss;
  logic                   free_any;
  logic [SIDX_W-1:0]      free_idx;

  ghamcc_ram #(
    .WIDTH($bits(map_word_t)),
    .DEPTH(MAP_ENTRIES)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .re_i   (m_re),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  ghamcc_ram #(
    .WIDTH($bits(cache_word_t)),
    .DEPTH(CACHE_SLOTS)
  ) u_cache_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .re_i   (c_re),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Lowest invalid cache slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = CACHE_SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_any = 1'b1;
        free_idx = SIDX_W'(s);
      end
    end
  end

  assign map_issue = (state_q == S_MSCAN) && (idx_q < CNT_W'(map_count_q));
  assign m_hit     = (state_q == S_MSCAN) && chk_q && (m_rdata.key == txn_q.virt_addr);
  assign m_miss    = (state_q == S_MSCAN) && !chk_q && !map_issue;
  assign c_issue   = (state_q == S_CSCAN) && (idx_q < CNT_W'(CACHE_SLOTS));
  assign c_hit     = (state_q == S_CSCAN) && chk_q && valid_q[chk_slot_q]
                     && (c_rdata.virt == txn_q.virt_addr);
  assign c_miss    = (state_q == S_CSCAN) && !chk_q && !c_issue;

  assign m_re    = map_issue;
  assign m_raddr = idx_q[MIDX_W-1:0];
  assign m_waddr = map_count_q[MIDX_W-1:0];
  assign m_wdata = '{key: txn_q.virt_addr, value: txn_q.host_addr_in};
  assign m_we    = m_miss && (txn_q.cmd == CMD_INSERT)
                   && (map_count_q < MCNT_W'(MAP_ENTRIES));

  assign c_re    = c_issue;
  assign c_raddr = idx_q[SIDX_W-1:0];
  assign c_waddr = free_idx;
  assign c_wdata = '{virt: in_data_i.ret_virt_addr, host: in_data_i.ret_host_addr};
  assign c_we    = in_acc && (in_data_i.cmd == CMD_CALL) && free_any;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    chk_d       = 1'b0;
    chk_slot_d  = chk_slot_q;
    map_count_d = map_count_q;
    valid_d     = valid_q;
    txn_d       = txn_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          txn_d = in_data_i;
          idx_d = '0;
          if (in_data_i.cmd == CMD_RETURN) begin
            state_d = S_CSCAN;
          end else begin
            state_d = S_MSCAN;
          end
          if (c_we) begin
            valid_d[free_idx] = 1'b1;
          end
        end
      end
      S_CSCAN: begin
        if (c_issue) begin
          idx_d      = idx_q + 1'b1;
          chk_d      = 1'b1;
          chk_slot_d = idx_q[SIDX_W-1:0];
        end
        if (c_hit) begin
          valid_d[chk_slot_q] = 1'b0;
          res_d   = '{host_addr: c_rdata.host, insert_dropped: 1'b0};
          chk_d   = 1'b0;
          state_d = S_DONE;
        end else if (c_miss) begin
          // fall back to the map
          idx_d   = '0;
          state_d = S_MSCAN;
        end
      end
      S_MSCAN: begin
        if (map_issue) begin
          idx_d = idx_q + 1'b1;
          chk_d = 1'b1;
        end
        if (m_hit) begin
          chk_d   = 1'b0;
          state_d = S_DONE;
          if (txn_q.cmd == CMD_INSERT) begin
            res_d = '{host_addr: '0, insert_dropped: 1'b0};
          end else begin
            res_d = '{host_addr: m_rdata.value, insert_dropped: 1'b0};
          end
        end else if (m_miss) begin
          state_d = S_DONE;
          res_d   = '{host_addr: '0, insert_dropped: 1'b0};
          if (txn_q.cmd == CMD_INSERT) begin
            if (m_we) begin
              map_count_d = map_count_q + 1'b1;
            end else begin
              res_d.insert_dropped = 1'b1;
            end
          end
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      chk_q       <= 1'b0;
      map_count_q <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      map_count_q <= map_count_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_slot_q <= chk_slot_d;
    txn_q      <= txn_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_count_q <= MCNT_W'(MAP_ENTRIES))
    else $error("map fill count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_count_q != $past(map_count_q)) |->
      (map_count_q == $past(map_count_q) + 1'b1) && ($past(txn_q.cmd) == CMD_INSERT))
    else $error("map fill count moved other than by one insert");

  a_call_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.cmd == CMD_CALL) && free_any) |=>
      ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("call with a free slot did not occupy exactly one slot");

  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_hit |=> !valid_q[$past(chk_slot_q)])
    else $error("cache hit left its slot valid");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !(out_valid_q && out_stall_i)) |=>
      (out_valid_q && (state_q == S_IDLE)))
    else $error("finished result not moved to the output register");

endmodule
